// ===== rtl/scalar_kalman_filter_assert.svh =====
// Assertion macros used by the checker of the scalar Kalman filter.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef SCALAR_KALMAN_FILTER_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("skf assertion failed");

// The consequent must hold starting in the cycle after the antecedent.
`define SKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("skf assertion failed");

`endif

// ===== rtl/skf_pkg.sv =====
// Package of the scalar Kalman filter: field widths, register indexes and
// sequencer states. Used by the channel interfaces and the top level.
`default_nettype none

package skf_pkg;

	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRED,
		ST_SETUP,
		ST_DIV,
		ST_MUL_EST,
		ST_MUL_COV,
		ST_COV,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/skf_if.sv =====
// Valid/ready channel interfaces for the sample input and the estimate output.
// Depends on skf_pkg for the payload width.
`default_nettype none

interface skf_sample_if;
	logic                              valid;
	logic                              ready;
	logic signed [skf_pkg::DATA_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface skf_estimate_if;
	logic                              valid;
	logic                              ready;
	logic signed [skf_pkg::DATA_W-1:0] estimate;

	modport source (output valid, output estimate, input ready);
	modport sink (input valid, input estimate, output ready);
endinterface

`default_nettype wire

// ===== rtl/scalar_kalman_filter.sv =====
// Top level of the scalar Kalman filter: sequencer, bit-serial gain divider
// and one shared multiplier. Depends on skf_pkg and the channel interfaces.
//
//   Channel    Role     Payload
//   samples    sink     sample, signed, FRAC_BITS fraction bits
//   estimates  source   estimate, signed, FRAC_BITS fraction bits
//   cfg        write    process_noise (index 0), measure_noise (index 1)
//
// An item goes from its transfer through the sequencer states to the output
// register; the divider in the DIV state makes one gain bit a cycle.
// The input is not ready while an item is in work; it is ready again as soon
// as the result is loaded, even while that result waits to be taken.
// A stalled output holds the sequencer before its last step.
// Reset restores the estimate, the covariance and both noise registers.
`default_nettype none

module scalar_kalman_filter #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [skf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [skf_pkg::DATA_W-1:0]     cfg_data,
	skf_sample_if.sink                     samples,
	skf_estimate_if.source                 estimates
);

	localparam int DW = skf_pkg::DATA_W;
	localparam int GW = FRAC_BITS + 1;
	localparam int MW = DW + 1;
	localparam int PW = GW + MW;
	localparam int NW = DW + FRAC_BITS + 1;
	localparam int CW = $clog2(GW);
	localparam int RW = PW - FRAC_BITS;

	localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
	localparam logic [DW-1:0] RESET_Q   = DW'((ONE_L + 64'd500) / 64'd1000);
	localparam logic [DW-1:0] RESET_R   = DW'((64'd543 * ONE_L + 64'd500) / 64'd1000);
	localparam logic [DW-1:0] RESET_COV = DW'((64'd2 * ONE_L + 64'd50) / 64'd100);
	localparam logic [GW-1:0] GAIN_ONE  = GW'(ONE_L);
	localparam logic [PW-1:0] HALF      = PW'(ONE_L >> 1);
	localparam logic [CW-1:0] DIV_LAST  = CW'(FRAC_BITS);

	skf_pkg::state_t state_q, state_nx;

	logic [DW-1:0] q_noise_q;
	logic [DW-1:0] r_noise_q;
	logic [DW-1:0] est_q;
	logic [DW-1:0] cov_q;
	logic [DW-1:0] sample_q;
	logic [DW-1:0] p_q;
	logic [MW-1:0] den_q;
	logic          den_zero_q;
	logic [MW-1:0] rem_q;
	logic [GW-1:0] num_q;
	logic [GW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] mag_q;
	logic          neg_q;
	logic [GW-1:0] gain_q;
	logic [PW-1:0] prod_q;
	logic          out_valid_q;
	logic [DW-1:0] out_data_q;

	logic [DW:0]   p_sum_w;
	logic [DW-1:0] p_w;
	logic [MW-1:0] den_w;
	logic [NW-1:0] num_w;
	logic [MW-1:0] innov_w;
	logic [MW-1:0] mag_w;
	logic [MW:0]   rem_sh_w;
	logic          ge_w;
	logic [MW:0]   rem_nx_w;
	logic [GW-1:0] gain_w;
	logic [GW-1:0] mul_a;
	logic [MW-1:0] mul_b;
	logic [PW-1:0] prod_w;
	logic [PW-1:0] rnd_w;
	logic [RW-1:0] scaled_w;
	logic [DW+2:0] next_w;
	logic [DW-1:0] est_nx_w;
	logic [DW-1:0] cov_nx_w;
	logic          emit_w;
	logic          in_xfer;

	assign in_xfer = samples.valid && samples.ready;

	// Predicted covariance, saturating.
	assign p_sum_w = {1'b0, cov_q} + {1'b0, q_noise_q};
	assign p_w     = p_sum_w[DW] ? {DW{1'b1}} : p_sum_w[DW-1:0];

	// Gain numerator with the rounding half of the denominator folded in.
	assign den_w   = {1'b0, p_q} + {1'b0, r_noise_q};
	assign num_w   = {1'b0, p_q, {FRAC_BITS{1'b0}}} + NW'(den_w >> 1);

	assign innov_w = {sample_q[DW-1], sample_q} - {est_q[DW-1], est_q};
	assign mag_w   = innov_w[MW-1] ? (~innov_w + MW'(1)) : innov_w;

	// One restoring division step.
	assign rem_sh_w = {rem_q, num_q[GW-1]};
	assign ge_w     = rem_sh_w >= {1'b0, den_q};
	assign rem_nx_w = ge_w ? (rem_sh_w - {1'b0, den_q}) : rem_sh_w;

	assign gain_w = den_zero_q ? '0 : ((quo_q > GAIN_ONE) ? GAIN_ONE : quo_q);

	assign prod_w   = {{MW{1'b0}}, mul_a} * {{GW{1'b0}}, mul_b};
	assign rnd_w    = prod_q + HALF;
	assign scaled_w = rnd_w[PW-1:FRAC_BITS];

	assign next_w = neg_q ? ({{3{est_q[DW-1]}}, est_q} - {1'b0, scaled_w})
	                      : ({{3{est_q[DW-1]}}, est_q} + {1'b0, scaled_w});

	always_comb begin
		if (!next_w[DW+2] && (|next_w[DW+1:DW-1])) begin
			est_nx_w = {1'b0, {(DW-1){1'b1}}};
		end else if (next_w[DW+2] && !(&next_w[DW+1:DW-1])) begin
			est_nx_w = {1'b1, {(DW-1){1'b0}}};
		end else begin
			est_nx_w = next_w[DW-1:0];
		end
	end

	assign cov_nx_w = (|scaled_w[RW-1:DW]) ? {DW{1'b1}} : scaled_w[DW-1:0];

	always_comb begin
		state_nx = state_q;
		case (state_q)
			skf_pkg::ST_IDLE: begin
				if (in_xfer) state_nx = skf_pkg::ST_PRED;
			end
			skf_pkg::ST_PRED:    state_nx = skf_pkg::ST_SETUP;
			skf_pkg::ST_SETUP:   state_nx = skf_pkg::ST_DIV;
			skf_pkg::ST_DIV: begin
				if (cnt_q == '0) state_nx = skf_pkg::ST_MUL_EST;
			end
			skf_pkg::ST_MUL_EST: state_nx = skf_pkg::ST_MUL_COV;
			skf_pkg::ST_MUL_COV: state_nx = skf_pkg::ST_COV;
			skf_pkg::ST_COV:     state_nx = skf_pkg::ST_EMIT;
			skf_pkg::ST_EMIT: begin
				if (emit_w) state_nx = skf_pkg::ST_IDLE;
			end
			default:             state_nx = skf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		samples.ready = 1'b0;
		emit_w        = 1'b0;
		mul_a         = gain_w;
		mul_b         = mag_q;
		case (state_q)
			skf_pkg::ST_IDLE:    samples.ready = 1'b1;
			skf_pkg::ST_MUL_COV: begin
				mul_a = GAIN_ONE - gain_q;
				mul_b = {1'b0, p_q};
			end
			skf_pkg::ST_EMIT:    emit_w = !out_valid_q || estimates.ready;
			default: begin
				samples.ready = 1'b0;
			end
		endcase
	end

	assign estimates.valid    = out_valid_q;
	assign estimates.estimate = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skf_pkg::ST_IDLE;
			q_noise_q   <= RESET_Q;
			r_noise_q   <= RESET_R;
			est_q       <= '0;
			cov_q       <= RESET_COV;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				if (cfg_index == skf_pkg::REG_PROCESS_NOISE) begin
					q_noise_q <= cfg_data;
				end else if (cfg_index == skf_pkg::REG_MEASURE_NOISE) begin
					r_noise_q <= cfg_data;
				end
			end
			if (state_q == skf_pkg::ST_SETUP) begin
				cnt_q <= DIV_LAST;
			end else if (state_q == skf_pkg::ST_DIV) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (state_q == skf_pkg::ST_MUL_COV) begin
				est_q <= est_nx_w;
			end
			if (state_q == skf_pkg::ST_COV) begin
				cov_q <= cov_nx_w;
			end
			if (emit_w) begin
				out_valid_q <= 1'b1;
			end else if (estimates.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= samples.sample;
		end
		if (state_q == skf_pkg::ST_PRED) begin
			p_q <= p_w;
		end
		if (state_q == skf_pkg::ST_SETUP) begin
			den_q      <= den_w;
			den_zero_q <= den_w == '0;
			rem_q      <= {1'b0, num_w[NW-1:GW]};
			num_q      <= num_w[GW-1:0];
			mag_q      <= mag_w;
			neg_q      <= innov_w[MW-1];
		end
		if (state_q == skf_pkg::ST_DIV) begin
			rem_q <= rem_nx_w[MW-1:0];
			num_q <= {num_q[GW-2:0], 1'b0};
			quo_q <= {quo_q[GW-2:0], ge_w};
		end
		if (state_q == skf_pkg::ST_MUL_EST) begin
			gain_q <= gain_w;
			prod_q <= prod_w;
		end
		if (state_q == skf_pkg::ST_MUL_COV) begin
			prod_q <= prod_w;
		end
		if (emit_w) begin
			out_data_q <= est_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/skf_checker.sv =====
// Port-level checker for the scalar Kalman filter, bound to the top level.
// Depends on the assertion macros in scalar_kalman_filter_assert.svh.
`default_nettype none

`include "scalar_kalman_filter_assert.svh"

module skf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_data
);

	logic       in_xfer;
	logic       out_xfer;
	logic [1:0] pending_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// Items taken in whose result has not yet been transferred out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_xfer && !in_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	`SKF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_xfer, !in_ready ##1 !in_ready)
	`SKF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`SKF_ASSERT_IMPL(a_no_extra_result, clk, arst_n, out_valid, pending_q != 2'd0)
	`SKF_ASSERT_IMPL(a_accept_room, clk, arst_n, in_xfer, pending_q != 2'd2)

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (estimates.valid),
	.out_ready (estimates.ready),
	.out_data  (estimates.estimate)
);

`default_nettype wire
